// ----- rtl/bba_pkg.sv -----
// Shared definitions for the bitmap block allocator: capacity, scan chunking,
// request and status codes. No dependencies.
package bba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int CHUNK_W      = 16;
  localparam int NUM_CHUNKS   = MAX_BLOCKS / CHUNK_W;
  localparam int CHUNK_IDX_W  = $clog2(NUM_CHUNKS);
  localparam int CHUNK_POS_W  = $clog2(CHUNK_W);
  localparam int IDX_W        = 6;
  localparam int COUNT_W      = 7;
  localparam int SHIFT_W      = 5;
  localparam int OFFSET_W     = 22;
  localparam int MAX_SHIFT    = 16;
  localparam int FUNC_W       = 3;
  localparam int STATUS_W     = 3;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // Register reset values
  localparam logic [COUNT_W-1:0] BLOCKS_IN_USE_RST   = COUNT_W'(64);
  localparam logic [SHIFT_W-1:0] BLOCK_SIZE_LOG2_RST = SHIFT_W'(6);

  // Register indexes
  localparam logic REG_BLOCKS_IN_USE   = 1'b0;
  localparam logic REG_BLOCK_SIZE_LOG2 = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESERVE_IDX  = 3'd0,
    FN_RESERVE_NEXT = 3'd1,
    FN_RELEASE      = 3'd2,
    FN_FETCH        = 3'd3,
    FN_QUERY        = 3'd4,
    FN_CLEAR        = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_ALREADY = 3'd2,
    ST_NOTRES  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

endpackage

// ----- rtl/bitmap_block_allocator_top.sv -----
// Bitmap block allocator: per-block reserved flags, reserved count and
// first-fit search. Depends on bba_pkg.
//
// Usage:
//   Requests arrive on the in_ valid/ready channel (in_func, in_block_index);
//   each produces exactly one result on the out_ valid/ready channel.
//   Configuration (blocks_in_use at 0x0, block_size_log2 at 0x4) is written
//   through the APB-style port; the user must write it only while the block
//   is idle, which the block does not enforce. pready is always high. Reserve
//   index, release, fetch, query and clear pass through the execute state to
//   the output register. Reserve next scans the flag map 16 blocks per cycle
//   with one shared priority encoder until the first free block, or to the
//   last chunk below blocks_in_use. No new request is taken before the result
//   of the last one is loaded; in_ready is high only while the sequencer is
//   idle, rising at the edge that loads the previous result. If the receiver
//   stalls, the result holds in the output register and a new request may
//   still be taken, finishing only once the output register is free.
//   Reset (rst_n low, synchronous) frees all blocks, zeroes the count and
//   restores blocks_in_use to 64 and block_size_log2 to 6.
module bitmap_block_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bba_pkg::FUNC_W-1:0]    in_func,
  input  logic [bba_pkg::IDX_W-1:0]     in_block_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::STATUS_W-1:0]  out_status,
  output logic [bba_pkg::IDX_W-1:0]     out_granted_index,
  output logic [bba_pkg::OFFSET_W-1:0]  out_byte_offset,
  output logic                          out_is_reserved,
  output logic [bba_pkg::COUNT_W-1:0]   out_reserved_count,
  output logic                          out_pool_full,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bba_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bba_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bba_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);

  import bba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [MAX_BLOCKS-1:0]     flags_r, flags_nxt;
  logic [COUNT_W-1:0]        count_r, count_nxt;
  logic [COUNT_W-1:0]        blocks_in_use_r;
  logic [SHIFT_W-1:0]        block_size_log2_r;
  logic [FUNC_W-1:0]         func_r;
  logic [IDX_W-1:0]          idx_r;
  logic [CHUNK_IDX_W-1:0]    chunk_r, chunk_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic [IDX_W-1:0]          granted_r, granted_nxt;
  logic [OFFSET_W-1:0]       offset_r, offset_nxt;
  logic                      flag_r, flag_nxt;
  logic                      full_r, full_nxt;

  logic [COUNT_W-1:0]        limit;
  logic [SHIFT_W-1:0]        shift_eff;
  logic                      in_range;
  logic                      cur_flag;
  logic                      out_free;
  logic                      give_offset;
  logic                      load_out;
  logic [CHUNK_W-1:0]        free_vec;
  logic                      hit;
  logic [CHUNK_POS_W-1:0]    hit_pos;
  logic [COUNT_W-1:0]        chunk_base;
  logic [COUNT_W-1:0]        chunk_end;
  logic                      last_chunk;
  logic                      cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_BLOCK_SIZE_LOG2)
                    ? APB_DATA_W'(block_size_log2_r)
                    : APB_DATA_W'(blocks_in_use_r);

  assign limit     = (blocks_in_use_r > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS)
                                                            : blocks_in_use_r;
  assign shift_eff = (block_size_log2_r > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT)
                                                             : block_size_log2_r;
  assign in_range  = COUNT_W'(idx_r) < limit;
  assign cur_flag  = flags_r[idx_r];
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  // Scan window: one chunk of the flag map, masked to blocks below the limit
  assign chunk_base = COUNT_W'(chunk_r) << CHUNK_POS_W;
  assign chunk_end  = chunk_base + COUNT_W'(CHUNK_W);
  assign last_chunk = (chunk_r == CHUNK_IDX_W'(NUM_CHUNKS - 1)) || (chunk_end >= limit);

  always_comb begin
    for (int j = 0; j < CHUNK_W; j++) begin
      free_vec[j] = !flags_r[{chunk_r, CHUNK_POS_W'(j)}] &&
                    ((chunk_base + COUNT_W'(j)) < limit);
    end
  end

  // Shared priority encoder: lowest free position in the window
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        hit     = 1'b1;
        hit_pos = CHUNK_POS_W'(j);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    count_nxt     = count_r;
    chunk_nxt     = chunk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    offset_nxt    = offset_r;
    flag_nxt      = flag_r;
    full_nxt      = full_r;
    give_offset   = 1'b0;
    load_out      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          chunk_nxt = '0;
          state_nxt = (in_func == FN_RESERVE_NEXT) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          load_out    = 1'b1;
          status_nxt  = ST_OK;
          granted_nxt = '0;
          flag_nxt    = 1'b0;
          case (func_r) inside
            FN_RESERVE_IDX, FN_RELEASE, FN_FETCH, FN_QUERY: begin
              granted_nxt = idx_r;
              if (!in_range) begin
                status_nxt = ST_RANGE;
              end else begin
                flag_nxt = cur_flag;
                case (func_r)
                  FN_RESERVE_IDX: begin
                    if (cur_flag) begin
                      status_nxt = ST_ALREADY;
                    end else begin
                      flags_nxt[idx_r] = 1'b1;
                      count_nxt        = count_r + COUNT_W'(1);
                      flag_nxt         = 1'b1;
                      give_offset      = 1'b1;
                    end
                  end
                  FN_RELEASE: begin
                    if (!cur_flag) begin
                      status_nxt = ST_NOTRES;
                    end else begin
                      flags_nxt[idx_r] = 1'b0;
                      count_nxt        = count_r - COUNT_W'(1);
                      flag_nxt         = 1'b0;
                    end
                  end
                  FN_FETCH: begin
                    if (!cur_flag) status_nxt = ST_NOTRES;
                    else           give_offset = 1'b1;
                  end
                  default: ;
                endcase
              end
            end
            FN_CLEAR: begin
              flags_nxt = '0;
              count_nxt = '0;
            end
            default: ;
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (out_free) begin
            load_out                      = 1'b1;
            flags_nxt[{chunk_r, hit_pos}] = 1'b1;
            count_nxt                     = count_r + COUNT_W'(1);
            status_nxt                    = ST_OK;
            granted_nxt                   = {chunk_r, hit_pos};
            flag_nxt                      = 1'b1;
            give_offset                   = 1'b1;
            state_nxt                     = S_IDLE;
          end
        end else if (last_chunk) begin
          if (out_free) begin
            load_out    = 1'b1;
            status_nxt  = ST_FULL;
            granted_nxt = '0;
            flag_nxt    = 1'b0;
            state_nxt   = S_IDLE;
          end
        end else begin
          chunk_nxt = chunk_r + CHUNK_IDX_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      offset_nxt    = give_offset ? OFFSET_W'({{(OFFSET_W-IDX_W){1'b0}}, granted_nxt} << shift_eff)
                                  : '0;
      full_nxt      = count_nxt >= limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      flags_r           <= '0;
      count_r           <= '0;
      out_valid_r       <= 1'b0;
      blocks_in_use_r   <= BLOCKS_IN_USE_RST;
      block_size_log2_r <= BLOCK_SIZE_LOG2_RST;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_BLOCK_SIZE_LOG2) block_size_log2_r <= pwdata[SHIFT_W-1:0];
        else                                 blocks_in_use_r   <= pwdata[COUNT_W-1:0];
      end
    end
    // payload, no reset needed
    chunk_r   <= chunk_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    offset_r  <= offset_nxt;
    flag_r    <= flag_nxt;
    full_r    <= full_nxt;
    if (in_valid && in_ready) begin
      func_r <= in_func;
      idx_r  <= in_block_index;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_granted_index  = granted_r;
  assign out_byte_offset    = offset_r;
  assign out_is_reserved    = flag_r;
  assign out_reserved_count = count_r;
  assign out_pool_full      = full_r;

`ifndef SYNTHESIS
  // count always tracks the number of set flags
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == COUNT_W'($countones(flags_r)))
    else $error("reserved count disagrees with flag map");

  // a new result only comes out of a working state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r != S_IDLE))
    else $error("result appeared without a request in progress");

  // one request at a time
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

  // full status never names a block
  a_full_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (granted_r == '0 && !flag_r))
    else $error("full status with a granted block");

  // a stalled result is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(granted_r) && $stable(status_r)))
    else $error("pending result changed under stall");
`endif

endmodule
